@@ hdl/tsched_pkg.sv @@
// Shared types and constants of the counter priority task scheduler.
// Holds the request and response words, opcodes, sequencer states and pick control.
// No dependencies.
package tsched_pkg;

	localparam int unsigned TSCHED_SLOTS_DEF = 64;
	localparam int unsigned TSCHED_SLICE_DEF = 8;
	localparam int unsigned TSCHED_PRIO_W    = 8;
	localparam int unsigned TSCHED_TASK_W    = 6;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_PAUSE = 2'd1,
		REQ_WAKE  = 2'd2,
		REQ_LOAD  = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WAKE,
		ST_RMW,
		ST_SCAN,
		ST_RELOAD
	} state_t;

	typedef struct packed {
		req_type_t                  req_type;
		logic [TSCHED_TASK_W-1:0]   task_index;
		logic                       entry_valid;
		logic [TSCHED_PRIO_W-1:0]   entry_priority;
		logic [7:0]                 entry_counter;
		logic                       entry_runnable;
	} sched_in_t;

	typedef struct packed {
		logic [TSCHED_TASK_W-1:0] next_task;
		logic                     switched;
		logic                     idle;
	} sched_out_t;

	typedef struct packed {
		logic clear;
		logic sample;
	} pick_ctl_t;

endpackage

@@ hdl/tsched_ram.sv @@
// Task table memory: one write port, one registered read port.
// Per-entry written flags make unwritten entries read as zero after reset.
// Depends on nothing but its parameters.
module tsched_ram #(
	parameter int unsigned DEPTH  = 64,
	parameter int unsigned WIDTH  = 18,
	parameter int unsigned ADDR_W = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] written_q;
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= written_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	// Written flags stand in for a clearing pass over the table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (wr_en) begin
			written_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hdl/tsched_pick.sv @@
// Running maximum tracker used while the sequencer sweeps the task table.
// Keeps the lowest index holding the largest nonzero slice value seen so far.
// Depends on tsched_pkg.
module tsched_pick #(
	parameter int unsigned TASK_SLOTS = 64,
	parameter int unsigned SLICE_BITS = 8,
	localparam int unsigned SLOT_W    = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tsched_pkg::pick_ctl_t ctl,
	input  logic                  cand_ok,
	input  logic [SLICE_BITS-1:0] cand_val,
	input  logic [SLOT_W-1:0]     cand_idx,
	output logic                  found,
	output logic [SLOT_W-1:0]     sel
);
	import tsched_pkg::*;

	logic [SLICE_BITS-1:0] best_q;
	logic [SLOT_W-1:0]     sel_q;
	logic                  found_q;

	// Strictly greater keeps the first index among equal values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q  <= '0;
			sel_q   <= '0;
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			best_q  <= '0;
			sel_q   <= '0;
			found_q <= 1'b0;
		end else if (ctl.sample && cand_ok && (cand_val > best_q)) begin
			best_q  <= cand_val;
			sel_q   <= cand_idx;
			found_q <= 1'b1;
		end
	end

	assign found = found_q;
	assign sel   = sel_q;

endmodule

@@ hdl/counter_priority_task_scheduler.sv @@
// Top level of the counter priority task scheduler: sequencer around the task table.
// Instantiates tsched_ram and tsched_pick; uses types from tsched_pkg.
//
//  channel   | ports                  | handshake
//  ----------+------------------------+------------------------------------------
//  request   | start, busy, req       | word taken at a clock edge with start & !busy
//  response  | done, rsp              | word valid for the one cycle done is high
//
// A load never raises busy. A wake of an in-range slot passes through the wake
// state, and a tick that leaves the slice counter nonzero through the RMW state.
// A schedule (pause, or a tick that empties the counter) sweeps the table through
// the single read port; when nothing is found, a second sweep reloads the counter
// of every valid entry while the pick runs again. Reset clears the table at once
// through per-entry written flags; there is no clearing pass. The receiver cannot
// stall, so the response goes out as a one-cycle strobe from its own register while
// the next word may be taken.
module counter_priority_task_scheduler #(
	parameter int unsigned TASK_SLOTS = tsched_pkg::TSCHED_SLOTS_DEF,
	parameter int unsigned SLICE_BITS = tsched_pkg::TSCHED_SLICE_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  tsched_pkg::sched_in_t  req,
	output logic                   done,
	output tsched_pkg::sched_out_t rsp
);
	import tsched_pkg::*;

	localparam int unsigned SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int unsigned WORD_W = 2 + TSCHED_PRIO_W + SLICE_BITS;
	localparam int unsigned CNT_W  = SLOT_W + 1;
	localparam logic [CNT_W-1:0] SLOT_END = CNT_W'(TASK_SLOTS);

	// Table word layout: valid, runnable, priority, slice counter.
	localparam int unsigned POS_VALID = WORD_W - 1;
	localparam int unsigned POS_RUN   = WORD_W - 2;
	localparam int unsigned POS_PRIO  = WORD_W - 3;

	state_t state_q, state_d;

	logic [CNT_W-1:0]  cnt_q;
	logic              vld_s1;
	logic [SLOT_W-1:0] idx_s1;
	req_type_t         op_q;
	logic [SLOT_W-1:0] idx_q;
	logic [SLOT_W-1:0] cur_q;
	logic              done_q;
	sched_out_t        rsp_q;

	// Memory port signals.
	logic              rd_en;
	logic [SLOT_W-1:0] rd_addr;
	logic [WORD_W-1:0] rd_data;
	logic              wr_en;
	logic [SLOT_W-1:0] wr_addr;
	logic [WORD_W-1:0] wr_data;

	// Pick unit signals.
	pick_ctl_t             pctl;
	logic                  cand_ok;
	logic [SLICE_BITS-1:0] cand_val;
	logic                  pick_found;
	logic [SLOT_W-1:0]     pick_sel;

	// Fields of the word just read.
	logic                     ent_valid;
	logic                     ent_run;
	logic [TSCHED_PRIO_W-1:0] ent_prio;
	logic [SLICE_BITS-1:0]    ent_cnt;
	logic [SLICE_BITS-1:0]    prio_fit;
	logic [SLICE_BITS-1:0]    cnt_dec;

	logic accept;
	logic in_rng;
	logic sched_go;
	logic scan_rd;
	logic scan_end;
	logic scan_clear;
	logic fin;
	logic fin_take;
	logic fin_idle;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign in_rng = int'(req.task_index) < TASK_SLOTS;

	assign ent_valid = rd_data[POS_VALID];
	assign ent_run   = rd_data[POS_RUN];
	assign ent_prio  = rd_data[POS_PRIO -: TSCHED_PRIO_W];
	assign ent_cnt   = rd_data[SLICE_BITS-1:0];
	assign prio_fit  = SLICE_BITS'(ent_prio);
	assign cnt_dec   = (ent_cnt != '0) ? (ent_cnt - 1'b1) : ent_cnt;

	// A tick reschedules once its counter sits at zero; a pause always does.
	assign sched_go = (op_q == REQ_PAUSE) || (cnt_dec == '0);
	assign scan_end = (cnt_q == SLOT_END) && !vld_s1;

	tsched_ram #(
		.DEPTH  (TASK_SLOTS),
		.WIDTH  (WORD_W),
		.ADDR_W (SLOT_W)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	tsched_pick #(
		.TASK_SLOTS (TASK_SLOTS),
		.SLICE_BITS (SLICE_BITS)
	) u_pick (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (pctl),
		.cand_ok  (cand_ok),
		.cand_val (cand_val),
		.cand_idx (idx_s1),
		.found    (pick_found),
		.sel      (pick_sel)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req.req_type) inside
						REQ_TICK, REQ_PAUSE: state_d = ST_RMW;
						REQ_WAKE:            state_d = in_rng ? ST_WAKE : ST_IDLE;
						default:             state_d = ST_IDLE;
					endcase
				end
			end
			ST_WAKE:   state_d = ST_IDLE;
			ST_RMW:    state_d = sched_go ? ST_SCAN : ST_IDLE;
			ST_SCAN: begin
				if (scan_end) begin
					state_d = pick_found ? ST_IDLE : ST_RELOAD;
				end
			end
			ST_RELOAD: begin
				if (scan_end) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Datapath controls per state.
	always_comb begin
		rd_en       = 1'b0;
		rd_addr     = '0;
		wr_en       = 1'b0;
		wr_addr     = '0;
		wr_data     = rd_data;
		pctl.clear  = 1'b0;
		pctl.sample = 1'b0;
		cand_ok     = ent_valid && ent_run;
		cand_val    = ent_cnt;
		scan_rd     = 1'b0;
		scan_clear  = 1'b0;
		fin         = 1'b0;
		fin_take    = 1'b0;
		fin_idle    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req.req_type) inside
						REQ_LOAD: begin
							// Out-of-range loads still answer, but leave the table alone.
							wr_en   = in_rng;
							wr_addr = SLOT_W'(req.task_index);
							wr_data = {req.entry_valid, req.entry_runnable,
								req.entry_priority, SLICE_BITS'(req.entry_counter)};
							fin     = 1'b1;
						end
						REQ_WAKE: begin
							rd_en   = in_rng;
							rd_addr = SLOT_W'(req.task_index);
							fin     = !in_rng;
						end
						default: begin
							rd_en   = 1'b1;
							rd_addr = cur_q;
						end
					endcase
				end
			end
			ST_WAKE: begin
				// Waking an empty slot is ignored.
				wr_en   = ent_valid;
				wr_addr = idx_q;
				wr_data = rd_data;
				wr_data[POS_RUN] = 1'b1;
				fin     = 1'b1;
			end
			ST_RMW: begin
				// The current slot is updated whether or not it holds a task.
				wr_en   = 1'b1;
				wr_addr = cur_q;
				wr_data = rd_data;
				if (op_q == REQ_PAUSE) begin
					wr_data[POS_RUN] = 1'b0;
				end else begin
					wr_data[SLICE_BITS-1:0] = cnt_dec;
				end
				pctl.clear = sched_go;
				scan_clear = sched_go;
				fin        = !sched_go;
			end
			ST_SCAN: begin
				scan_rd     = (cnt_q < SLOT_END);
				rd_en       = scan_rd;
				rd_addr     = cnt_q[SLOT_W-1:0];
				pctl.sample = vld_s1;
				if (scan_end) begin
					fin        = pick_found;
					fin_take   = pick_found;
					pctl.clear = !pick_found;
					scan_clear = !pick_found;
				end
			end
			ST_RELOAD: begin
				// Every valid counter is refilled while the second pick runs on
				// the refilled values; reads run one slot ahead of the write.
				scan_rd     = (cnt_q < SLOT_END);
				rd_en       = scan_rd;
				rd_addr     = cnt_q[SLOT_W-1:0];
				wr_en       = vld_s1 && ent_valid;
				wr_addr     = idx_s1;
				wr_data     = rd_data;
				wr_data[SLICE_BITS-1:0] = prio_fit;
				cand_val    = prio_fit;
				pctl.sample = vld_s1;
				if (scan_end) begin
					fin      = 1'b1;
					fin_take = pick_found;
					fin_idle = !pick_found;
				end
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			cur_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= scan_rd;
			done_q  <= fin;
			if (scan_clear) begin
				cnt_q <= '0;
			end else if (scan_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (fin_take) begin
				cur_q <= pick_sel;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[SLOT_W-1:0];
		if (accept) begin
			op_q  <= req.req_type;
			idx_q <= SLOT_W'(req.task_index);
		end
		if (fin) begin
			rsp_q.next_task <= TSCHED_TASK_W'(fin_take ? pick_sel : cur_q);
			rsp_q.switched  <= fin_take && (pick_sel != cur_q);
			rsp_q.idle      <= fin_idle;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// A load is answered in the very next cycle.
	a_load_answer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.req_type == REQ_LOAD) |=> done)
		else $error("load word not answered in the following cycle");

	// The sequencer never reads an entry in the cycle it writes it.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en && (rd_addr == wr_addr)))
		else $error("read and write of the same table entry in one cycle");

	// The sweep counter stops at the table depth.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= SLOT_END)
		else $error("sweep counter ran past the table");

	// An idle answer keeps the current task.
	a_idle_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.idle |-> !rsp.switched)
		else $error("idle answer reported a task switch");

endmodule

@@ tb/tsched_checker.sv @@
// Checker for the counter priority task scheduler: watches the request and response
// channels, keeps its own copy of the task table and compares every response word.
// Depends on tsched_pkg for the word types and opcodes.
module tsched_checker #(
	parameter int unsigned TASK_SLOTS = tsched_pkg::TSCHED_SLOTS_DEF,
	parameter int unsigned SLICE_BITS = tsched_pkg::TSCHED_SLICE_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   busy,
	input  tsched_pkg::sched_in_t  req,
	input  logic                   done,
	input  tsched_pkg::sched_out_t rsp,
	output int unsigned            mismatches,
	output int unsigned            outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import tsched_pkg::*;

	logic                      slot_used  [TASK_SLOTS];
	logic                      slot_ready [TASK_SLOTS];
	logic [SLICE_BITS-1:0]     slice_left [TASK_SLOTS];
	logic [TSCHED_PRIO_W-1:0]  refill     [TASK_SLOTS];
	logic [TSCHED_TASK_W-1:0]  running;

	sched_out_t  rsp_due[$];
	int unsigned fail_tally;
	int unsigned due_count;

	assign mismatches  = fail_tally;
	assign outstanding = due_count;

	// Lowest-indexed ready task with the largest nonzero slice, or -1.
	function automatic int busiest_slot();
		int                    sel;
		logic [SLICE_BITS-1:0] best;
		sel  = -1;
		best = '0;
		for (int k = 0; k < TASK_SLOTS; k++) begin
			if (slot_used[k] && slot_ready[k] && slice_left[k] > best) begin
				best = slice_left[k];
				sel  = k;
			end
		end
		return sel;
	endfunction

	// Picks a task, refilling the slice of every used slot once if needed. Returns 1 when nothing can run.
	function automatic logic reschedule();
		int sel;
		sel = busiest_slot();
		if (sel < 0) begin
			for (int k = 0; k < TASK_SLOTS; k++) begin
				if (slot_used[k])
					slice_left[k] = SLICE_BITS'(refill[k]);
			end
			sel = busiest_slot();
		end
		if (sel < 0)
			return 1'b1;
		running = sel[TSCHED_TASK_W-1:0];
		return 1'b0;
	endfunction

	function automatic sched_out_t schedule_outcome(sched_in_t w);
		sched_out_t               r;
		logic [TSCHED_TASK_W-1:0] prior;
		logic                     none;
		prior = running;
		none  = 1'b0;
		case (w.req_type)
			REQ_TICK: begin
				if (slice_left[running] != '0)
					slice_left[running] = slice_left[running] - 1'b1;
				if (slice_left[running] == '0)
					none = reschedule();
			end
			REQ_PAUSE: begin
				slot_ready[running] = 1'b0;
				none = reschedule();
			end
			REQ_WAKE: begin
				if (w.task_index < TASK_SLOTS && slot_used[w.task_index])
					slot_ready[w.task_index] = 1'b1;
			end
			REQ_LOAD: begin
				if (w.task_index < TASK_SLOTS) begin
					slot_used[w.task_index]  = w.entry_valid;
					refill[w.task_index]     = w.entry_priority;
					slice_left[w.task_index] = SLICE_BITS'(w.entry_counter);
					slot_ready[w.task_index] = w.entry_runnable;
				end
			end
		endcase
		r.next_task = running;
		r.switched  = (running != prior);
		r.idle      = none;
		return r;
	endfunction

	function automatic int unsigned field_differs(string name, logic [7:0] want,
			logic [7:0] got);
		if (got === want)
			return 0;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sched_out_t want;
		if (!arst_n) begin
			for (int k = 0; k < TASK_SLOTS; k++) begin
				slot_used[k]  = 1'b0;
				slot_ready[k] = 1'b0;
				slice_left[k] = '0;
				refill[k]     = '0;
			end
			running    = '0;
			rsp_due.delete();
			fail_tally = 0;
			due_count  = 0;
		end else begin
			if (start && !busy)
				rsp_due.push_back(schedule_outcome(req));
			if (done === 1'b1) begin
				if (rsp_due.size() == 0) begin
					$display("%0t: response word with none expected, actual %p", $time, rsp);
					fail_tally++;
				end else begin
					want = rsp_due.pop_front();
					fail_tally += field_differs("next_task", 8'(want.next_task),
						8'(rsp.next_task));
					fail_tally += field_differs("switched", 8'(want.switched),
						8'(rsp.switched));
					fail_tally += field_differs("idle", 8'(want.idle), 8'(rsp.idle));
				end
			end
			due_count = rsp_due.size();
		end
	end

endmodule

@@ tb/counter_priority_task_scheduler_tb.sv @@
// Top of the testbench for the counter priority task scheduler: clock, reset and request words.
// Instantiates the block and tsched_checker; uses types and opcodes from tsched_pkg.
module counter_priority_task_scheduler_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tsched_pkg::*;

	// Number of random request words, and how many at the end go out back to back.
	localparam int unsigned RANDOM_WORDS = 1200;
	localparam int unsigned CALM_TAIL    = 150;
	// Extra wait at the end, longer than a schedule with a full reload takes.
	localparam int unsigned DRAIN_CYCLES = 150;
	// Time limit in ns, well above the slowest correct run.
	localparam int unsigned TIMEOUT_NS   = 8_000_000;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic       done;
	sched_in_t  req;
	sched_out_t rsp;

	int unsigned mismatches;
	int unsigned outstanding;

	counter_priority_task_scheduler u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	// The checker sees the same ports and keeps the expected response words.
	tsched_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.done        (done),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Safety net: a hung handshake or a lost response word ends the run here.
	initial begin
		#(TIMEOUT_NS);
		$display("counter_priority_task_scheduler_tb NOT OK");
		$finish;
	end

	function automatic sched_in_t make_word(req_type_t op, logic [5:0] idx, logic valid,
			logic [7:0] prio, logic [7:0] count, logic ready);
		sched_in_t w;
		w.req_type       = op;
		w.task_index     = idx;
		w.entry_valid    = valid;
		w.entry_priority = prio;
		w.entry_counter  = count;
		w.entry_runnable = ready;
		return w;
	endfunction

	// Random request word. Most loads and wakes land on a small group of slots with
	// short slices, so that ticks actually run slices out and schedules find work.
	// Now and then a field takes its whole range, so every bit toggles.
	function automatic sched_in_t random_word();
		sched_in_t   w;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 30)
			w.req_type = REQ_TICK;
		else if (roll < 45)
			w.req_type = REQ_PAUSE;
		else if (roll < 65)
			w.req_type = REQ_WAKE;
		else
			w.req_type = REQ_LOAD;
		w.task_index     = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
		w.entry_valid    = ($urandom_range(0, 7) != 0);
		w.entry_priority = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
		w.entry_counter  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
		w.entry_runnable = ($urandom_range(0, 3) != 0);
		return w;
	endfunction

	// Presents a word from a falling edge and holds it until a rising edge sees busy low.
	// Returns at the next falling edge with start still high, so back-to-back words
	// never lower and raise start in the same step.
	task automatic send_word(input sched_in_t w);
		start <= 1'b1;
		req   <= w;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		@(negedge clk);
	endtask

	// Sender goes quiet; the request lines carry junk meanwhile.
	task automatic hold_off(input int unsigned cycles);
		start <= 1'b0;
		req   <= random_word();
		repeat (cycles) @(negedge clk);
	endtask

	// Sender goes quiet until every expected response word has come back.
	task automatic wait_for_responses();
		start <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. An empty table: a tick and a pause find nothing to run,
		// and waking an empty slot is ignored.
		send_word(make_word(REQ_TICK,  6'd0,  1'b0, 8'd0,   8'd0,   1'b0));
		send_word(make_word(REQ_PAUSE, 6'd0,  1'b1, 8'hff, 8'hff, 1'b1));
		send_word(make_word(REQ_WAKE,  6'd5,  1'b0, 8'd0,   8'd0,   1'b0));
		// Field extremes; slots 0 and 10 tie on the largest slice.
		send_word(make_word(REQ_LOAD,  6'd0,  1'b1, 8'hff, 8'hff, 1'b1));
		send_word(make_word(REQ_LOAD,  6'd63, 1'b1, 8'd0,   8'd0,   1'b1));
		send_word(make_word(REQ_LOAD,  6'd10, 1'b1, 8'd128, 8'hff, 1'b1));
		// Pausing slot 0 switches to slot 10; a tick then leaves its slice nonzero.
		send_word(make_word(REQ_PAUSE, 6'd0,  1'b0, 8'd0,   8'd0,   1'b0));
		send_word(make_word(REQ_TICK,  6'd0,  1'b0, 8'd0,   8'd0,   1'b0));
		send_word(make_word(REQ_WAKE,  6'd0,  1'b0, 8'd0,   8'd0,   1'b0));
		send_word(make_word(REQ_PAUSE, 6'd0,  1'b0, 8'd0,   8'd0,   1'b0));
		// A tick that empties the current slice forces a refill and keeps the same task.
		send_word(make_word(REQ_LOAD,  6'd0,  1'b1, 8'hff, 8'd1,   1'b1));
		send_word(make_word(REQ_TICK,  6'd0,  1'b0, 8'd0,   8'd0,   1'b0));
		// An empty slot marked runnable is never picked, and cannot be woken.
		send_word(make_word(REQ_LOAD,  6'd1,  1'b0, 8'd200, 8'd200, 1'b1));
		send_word(make_word(REQ_WAKE,  6'd1,  1'b0, 8'd0,   8'd0,   1'b0));
		// The current slot is emptied; ticks and a pause still act on it, and the
		// pause ends with nothing to run even after the refill.
		send_word(make_word(REQ_LOAD,  6'd0,  1'b0, 8'd7,   8'd3,   1'b1));
		send_word(make_word(REQ_TICK,  6'd0,  1'b0, 8'd0,   8'd0,   1'b0));
		send_word(make_word(REQ_PAUSE, 6'd0,  1'b0, 8'd0,   8'd0,   1'b0));
		send_word(make_word(REQ_WAKE,  6'd63, 1'b0, 8'd0,   8'd0,   1'b0));
		send_word(make_word(REQ_LOAD,  6'd63, 1'b1, 8'd1,   8'd0,   1'b1));
		send_word(make_word(REQ_TICK,  6'd0,  1'b0, 8'd0,   8'd0,   1'b0));
		send_word(make_word(REQ_TICK,  6'd0,  1'b0, 8'd0,   8'd0,   1'b0));
		send_word(make_word(REQ_TICK,  6'd0,  1'b0, 8'd0,   8'd0,   1'b0));
		// A tick on a slice that is already zero, with a zero priority behind it.
		send_word(make_word(REQ_LOAD,  6'd63, 1'b1, 8'd0,   8'd0,   1'b1));
		send_word(make_word(REQ_TICK,  6'd0,  1'b0, 8'd0,   8'd0,   1'b0));
		send_word(make_word(REQ_WAKE,  6'd10, 1'b0, 8'd0,   8'd0,   1'b0));
		wait_for_responses();

		// Random part. Every third block of 100 words runs without gaps, the others
		// get short random hold-offs, and the tail goes out back to back.
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == RANDOM_WORDS / 4 || i == RANDOM_WORDS / 2)
				wait_for_responses();
			if (i < RANDOM_WORDS - CALM_TAIL && (i / 100) % 3 != 2 &&
					$urandom_range(0, 4) == 0)
				hold_off($urandom_range(1, 7));
			send_word(random_word());
		end

		wait_for_responses();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("counter_priority_task_scheduler_tb OK");
		else
			$display("counter_priority_task_scheduler_tb NOT OK");
		$finish;
	end

endmodule
